@@ design/integer_literal_parser_top_macros.svh @@
// assertion helpers used by the parser module ilp_parse
// every assertion samples on clk and is off while rst_n is low
`ifndef INTEGER_LITERAL_PARSER_TOP_MACROS_SVH
`define INTEGER_LITERAL_PARSER_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ILP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ILP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ilp_pkg.sv @@
package ilp_pkg;

    localparam int CHAR_W     = 8;
    localparam int VALUE_W    = 64;
    localparam int STATUS_W   = 2;
    localparam int DIGIT_W    = 4;
    localparam int IN_TDATA_W = 8;
    localparam int OUT_TDATA_W = ((VALUE_W + STATUS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_TDATA_W - VALUE_W - STATUS_W;

    localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_ONE     = 8'h31;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LOW_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_B   = 8'h62;
    localparam logic [CHAR_W-1:0] CH_LOW_F   = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LOW_X   = 8'h78;

    // 'a' has low nibble 1, so adding 9 gives digit ten
    localparam logic [DIGIT_W-1:0] HEX_ALPHA_OFFSET = 4'd9;

    typedef enum logic [3:0] {
        PH_START  = 4'b0001,
        PH_SIGNED = 4'b0010,
        PH_ZERO   = 4'b0100,
        PH_DIGITS = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_BIN = 2'd1,
        RX_HEX = 2'd2
    } radix_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_DIGIT = 2'd1,
        ST_MACRO = 2'd2
    } status_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        status_t                   status;
    } result_t;

    typedef struct packed {
        logic               ok;
        logic [DIGIT_W-1:0] val;
    } digit_t;

    function automatic digit_t decode_digit(logic [CHAR_W-1:0] c, radix_t r);
        digit_t d;
        d.ok  = 1'b0;
        d.val = '0;
        unique case (r)
            RX_BIN:
            begin
                if (c == CH_ZERO || c == CH_ONE)
                begin
                    d.ok  = 1'b1;
                    d.val = c[DIGIT_W-1:0];
                end
            end
            RX_HEX:
            begin
                if (c >= CH_ZERO && c <= CH_NINE)
                begin
                    d.ok  = 1'b1;
                    d.val = c[DIGIT_W-1:0];
                end
                else if (c >= CH_LOW_A && c <= CH_LOW_F)
                begin
                    d.ok  = 1'b1;
                    d.val = c[DIGIT_W-1:0] + HEX_ALPHA_OFFSET;
                end
            end
            default:
            begin
                if (c >= CH_ZERO && c <= CH_NINE)
                begin
                    d.ok  = 1'b1;
                    d.val = c[DIGIT_W-1:0];
                end
            end
        endcase
        return d;
    endfunction

endpackage

@@ design/ilp_in_stage.sv @@
module ilp_in_stage
    import ilp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_valid,
    output logic  s_ready,
    input  item_t s_item,
    output logic  item_valid,
    output item_t item,
    input  logic  pop
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    // slot is free when empty or when the parser drains it this cycle
    assign s_ready = !valid_reg || pop;
    assign take    = s_valid && s_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ design/ilp_parse.sv @@
module ilp_parse
    import ilp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  item_t   item,
    output logic    pop,
    input  logic    out_free,
    output logic    load,
    output result_t result
);

`include "integer_literal_parser_top_macros.svh"

    // accumulator holds the signed running value, so a '-' token subtracts digits
    logic [VALUE_W-1:0] acc_reg;
    logic [VALUE_W-1:0] acc_next;
    phase_t             phase_reg;
    phase_t             phase_next;
    radix_t             radix_reg;
    radix_t             radix_next;
    logic               neg_reg;
    logic               neg_next;
    status_t            err_reg;
    status_t            err_next;

    radix_t             eff_radix;
    digit_t             dig;
    logic [VALUE_W-1:0] scaled;
    logic [VALUE_W-1:0] dig_ext;
    logic [VALUE_W-1:0] acc_take;
    logic               take_char;
    logic [CHAR_W-1:0]  c;

    assign c = item.char_code;

    // a last item waits until the result register can take it
    assign pop  = item_valid && (!item.last_char || out_free);
    assign load = pop && item.last_char;

    // digits seen before the digit phase are always decimal
    assign eff_radix = (phase_reg == PH_DIGITS) ? radix_reg : RX_DEC;
    assign dig       = decode_digit(c, eff_radix);
    assign dig_ext   = {{(VALUE_W - DIGIT_W){1'b0}}, dig.val};

    always_comb
    begin
        case (eff_radix)
            RX_BIN:  scaled = {acc_reg[VALUE_W-2:0], 1'b0};
            RX_HEX:  scaled = {acc_reg[VALUE_W-5:0], 4'b0000};
            default: scaled = {acc_reg[VALUE_W-4:0], 3'b000} + {acc_reg[VALUE_W-2:0], 1'b0};
        endcase
        acc_take = neg_reg ? (scaled - dig_ext) : (scaled + dig_ext);
    end

    always_comb
    begin
        acc_next   = acc_reg;
        phase_next = phase_reg;
        radix_next = radix_reg;
        neg_next   = neg_reg;
        err_next   = err_reg;
        take_char  = 1'b0;

        if (pop && err_reg == ST_OK)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    if (c == CH_PERCENT)
                    begin
                        err_next   = ST_MACRO;
                        phase_next = PH_DIGITS;
                    end
                    else if (c == CH_MINUS)
                    begin
                        neg_next   = 1'b1;
                        phase_next = PH_SIGNED;
                    end
                    else if (c == CH_ZERO)
                    begin
                        phase_next = PH_ZERO;
                    end
                    else
                    begin
                        radix_next = RX_DEC;
                        take_char  = 1'b1;
                    end
                end
                PH_SIGNED:
                begin
                    if (c == CH_ZERO)
                    begin
                        phase_next = PH_ZERO;
                    end
                    else
                    begin
                        radix_next = RX_DEC;
                        take_char  = 1'b1;
                    end
                end
                PH_ZERO:
                begin
                    if (c == CH_LOW_B)
                    begin
                        radix_next = RX_BIN;
                        phase_next = PH_DIGITS;
                    end
                    else if (c == CH_LOW_X)
                    begin
                        radix_next = RX_HEX;
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        radix_next = RX_DEC;
                        take_char  = 1'b1;
                    end
                end
                default:
                begin
                    take_char = 1'b1;
                end
            endcase

            if (take_char)
            begin
                phase_next = PH_DIGITS;
                if (dig.ok)
                begin
                    acc_next = acc_take;
                end
                else
                begin
                    err_next = ST_DIGIT;
                end
            end
        end

        result.status = err_next;
        result.value  = (err_next == ST_OK) ? acc_next : '0;

        // token done: back to the start of the next token
        if (load)
        begin
            acc_next   = '0;
            phase_next = PH_START;
            radix_next = RX_DEC;
            neg_next   = 1'b0;
            err_next   = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            phase_reg <= PH_START;
            radix_reg <= RX_DEC;
            neg_reg   <= 1'b0;
            err_reg   <= ST_OK;
        end
        else
        begin
            acc_reg   <= acc_next;
            phase_reg <= phase_next;
            radix_reg <= radix_next;
            neg_reg   <= neg_next;
            err_reg   <= err_next;
        end
    end

    `ILP_ASSERT_NEXT(a_token_restart, load, (phase_reg == PH_START && err_reg == ST_OK && acc_reg == '0), "parser state not cleared after token end")
    `ILP_ASSERT_NEXT(a_error_freezes_acc, (pop && !item.last_char && err_reg != ST_OK), $stable(acc_reg), "accumulator moved after an error")
    `ILP_ASSERT_NOW(a_error_zero_value, (load && result.status != ST_OK), (result.value == '0), "nonzero value reported with error status")
    `ILP_ASSERT_NOW(a_load_needs_slot, load, out_free, "result produced while output slot busy")

endmodule

@@ design/ilp_out_stage.sv @@
module ilp_out_stage
    import ilp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  result_t                result,
    output logic                   out_free,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [OUT_TDATA_W-1:0] m_data
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign out_free = !valid_reg || m_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = {{OUT_PAD_W{1'b0}}, data_reg.status, data_reg.value};

endmodule

@@ design/integer_literal_parser_top.sv @@
// integer literal parser: feed the characters of one immediate-operand token on the
// slave stream, one per request, with tlast on the final character; after that
// character one result request leaves on the master stream carrying the signed 64-bit
// value and a status (0 ok, 1 invalid digit for the base, 2 leading '%' macro token,
// value forced to 0 when status is not ok); an optional leading '-' negates, "0b"
// selects binary, "0x" lowercase hex, anything else is decimal, digits wrap modulo
// 2^64, and the first error sticks while the rest of the token is absorbed; the block
// takes one character every cycle with no gap between tokens unless a last character
// waits as told below; a character is parsed while it sits in the input register, and
// a token's result is written into the output register at the next edge, so the last
// character passes the input register and then the output register before m_axis_tvalid
// shows its result, and the result leaves once the master side is ready;
// while the output register holds a result that the master side has not taken, a last
// character waits in the input register and s_axis_tready drops, but other characters
// keep flowing; the per-character path is one scale-and-add on the 64-bit accumulator
module integer_literal_parser_top
    import ilp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // character stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] char_code
    input  logic                   s_axis_tlast,   // last_char
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [63:0] value, [65:64] status, rest zero
);

    item_t   s_item;
    logic    item_valid;
    item_t   item;
    logic    pop;
    logic    out_free;
    logic    load;
    result_t result;

    assign s_item.char_code = s_axis_tdata[CHAR_W-1:0];
    assign s_item.last_char = s_axis_tlast;

    // input register, refilled in the same cycle it drains
    ilp_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .pop        (pop)
    );

    // token state machine and digit accumulation
    ilp_parse u_parse
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .pop        (pop),
        .out_free   (out_free),
        .load       (load),
        .result     (result)
    );

    // result register toward the master side
    ilp_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .result   (result),
        .out_free (out_free),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_data   (m_axis_tdata)
    );

endmodule
